// ===== design/mie_pkg.sv =====
package mie_pkg;

    localparam int XLEN = 32;
    localparam int NREGS = 32;
    localparam int QDEPTH = 2;

    // opcodes
    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_JAL   = 6'h03;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_ADDIU = 6'h09;
    localparam logic [5:0] OP_SLTI  = 6'h0a;
    localparam logic [5:0] OP_SLTIU = 6'h0b;
    localparam logic [5:0] OP_ANDI  = 6'h0c;
    localparam logic [5:0] OP_ORI   = 6'h0d;

    // function codes
    localparam logic [5:0] FN_SLL   = 6'h00;
    localparam logic [5:0] FN_SRL   = 6'h02;
    localparam logic [5:0] FN_JR    = 6'h08;
    localparam logic [5:0] FN_MFHI  = 6'h10;
    localparam logic [5:0] FN_MFLO  = 6'h12;
    localparam logic [5:0] FN_MULT  = 6'h18;
    localparam logic [5:0] FN_MULTU = 6'h19;
    localparam logic [5:0] FN_DIV   = 6'h1a;
    localparam logic [5:0] FN_DIVU  = 6'h1b;
    localparam logic [5:0] FN_ADD   = 6'h20;
    localparam logic [5:0] FN_ADDU  = 6'h21;
    localparam logic [5:0] FN_SUB   = 6'h22;
    localparam logic [5:0] FN_SUBU  = 6'h23;
    localparam logic [5:0] FN_AND   = 6'h24;
    localparam logic [5:0] FN_OR    = 6'h25;
    localparam logic [5:0] FN_XOR   = 6'h26;
    localparam logic [5:0] FN_NOR   = 6'h27;
    localparam logic [5:0] FN_SLT   = 6'h2a;
    localparam logic [5:0] FN_SLTU  = 6'h2b;

    // operation class decided by the front end
    typedef enum logic [2:0] {
        CL_ALU = 3'd0,
        CL_MUL = 3'd1,
        CL_DIV = 3'd2,
        CL_BAD = 3'd3
    } op_class_t;

    typedef struct packed {
        logic [31:0] instr;
        op_class_t   cls;
        logic        sgn;
    } dec_word_t;

    // iterative unit states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIX  = 4'b1000
    } ex_state_t;

endpackage

// ===== design/mie_front.sv =====
module mie_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    output logic               ready,
    input  logic [31:0]        instr,
    output logic               q_valid,
    input  logic               q_ready,
    output mie_pkg::dec_word_t q_word
);
    import mie_pkg::*;

    dec_word_t w_in;
    logic [5:0] op, fn;
    logic [QDEPTH-1:0] vld_reg, vld_next;
    dec_word_t mem_reg [QDEPTH];
    logic wp_reg, rp_reg;
    logic push, pop;

    // classify the instruction
    always_comb
    begin
        op = instr[31:26];
        fn = instr[5:0];
        w_in.instr = instr;
        w_in.sgn = 1'b0;
        w_in.cls = CL_ALU;
        if (op == OP_RTYPE)
        begin
            case (fn)
                FN_MULT:  begin w_in.cls = CL_MUL; w_in.sgn = 1'b1; end
                FN_MULTU: w_in.cls = CL_MUL;
                FN_DIV:   begin w_in.cls = CL_DIV; w_in.sgn = 1'b1; end
                FN_DIVU:  w_in.cls = CL_DIV;
                FN_SLL, FN_SRL, FN_JR, FN_MFHI, FN_MFLO, FN_ADD, FN_ADDU,
                FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT,
                FN_SLTU:  w_in.cls = CL_ALU;
                default:  w_in.cls = CL_BAD;
            endcase
        end
        else if (!(op inside {OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDI, OP_ADDIU,
                              OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI}))
        begin
            w_in.cls = CL_BAD;
        end
    end

    assign ready   = !vld_reg[wp_reg];
    assign push    = valid && ready;
    assign q_valid = vld_reg[rp_reg];
    assign pop     = q_valid && q_ready;
    assign q_word  = mem_reg[rp_reg];

    // track occupied slots
    always_comb
    begin
        vld_next = vld_reg;
        if (pop)
            vld_next[rp_reg] = 1'b0;
        if (push)
            vld_next[wp_reg] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
        end
    end

    // store the word
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= w_in;
    end

endmodule

// ===== design/mie_back.sv =====
module mie_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  mie_pkg::dec_word_t q_word,
    output logic               valid,
    input  logic               ready,
    output logic [31:0]        next_pc,
    output logic               reg_write,
    output logic [4:0]         reg_index,
    output logic [31:0]        reg_value,
    output logic               overflow,
    output logic               unsupported
);
    import mie_pkg::*;

    logic [31:0] regs_reg [NREGS];
    logic [NREGS-1:0] rvld_reg;
    logic [31:0] hi_reg, lo_reg, pc_reg;
    ex_state_t st_reg;
    logic [5:0] cnt_reg;
    logic [63:0] acc_reg;
    logic [31:0] mcand_reg, dvs_reg;
    logic neg_reg, rneg_reg;
    logic ov_reg;

    logic [31:0] w, a, b, si, zi, val, npc;
    logic [5:0] op, fn;
    logic [4:0] rs, rt, rd, sh, dst;
    logic wr, ovf, bad, fire, start_mul, start_div, finish;
    logic [31:0] abs_a, abs_b;
    logic [32:0] dsub;
    logic [32:0] prod;
    logic [63:0] mdone;
    logic [31:0] q_fix, r_fix, sum_ab, dif_ab, sum_ai;

    assign w  = q_word.instr;
    assign op = w[31:26];
    assign fn = w[5:0];
    assign rs = w[25:21];
    assign rt = w[20:16];
    assign rd = w[15:11];
    assign sh = w[10:6];
    assign a  = rvld_reg[rs] ? regs_reg[rs] : '0;
    assign b  = rvld_reg[rt] ? regs_reg[rt] : '0;
    assign si = {{16{w[15]}}, w[15:0]};
    assign zi = {16'h0, w[15:0]};
    assign abs_a = (q_word.sgn && a[31]) ? (32'd0 - a) : a;
    assign abs_b = (q_word.sgn && b[31]) ? (32'd0 - b) : b;
    assign sum_ab = a + b;
    assign dif_ab = a - b;
    assign sum_ai = a + si;

    // simple instructions
    always_comb
    begin
        npc = pc_reg + 32'd32;
        wr  = 1'b1;
        ovf = 1'b0;
        bad = 1'b0;
        val = '0;
        dst = rd;
        if (op == OP_RTYPE)
        begin
            case (fn)
                FN_SLL:  val = b << sh;
                FN_SRL:  val = b >> sh;
                FN_JR:   begin wr = 1'b0; npc = a; end
                FN_MFHI: val = hi_reg;
                FN_MFLO: val = lo_reg;
                FN_MULT, FN_MULTU, FN_DIV, FN_DIVU: wr = 1'b0;
                FN_ADD:  begin val = sum_ab; ovf = ~(a[31] ^ b[31]) & (a[31] ^ val[31]); end
                FN_ADDU: val = sum_ab;
                FN_SUB:  begin val = dif_ab; ovf = (a[31] ^ b[31]) & (a[31] ^ val[31]); end
                FN_SUBU: val = dif_ab;
                FN_AND:  val = a & b;
                FN_OR:   val = a | b;
                FN_XOR:  val = a ^ b;
                FN_NOR:  val = ~(a | b);
                FN_SLT:  val = {31'd0, $signed(a) < $signed(b)};
                FN_SLTU: val = {31'd0, a < b};
                default: begin wr = 1'b0; bad = 1'b1; end
            endcase
        end
        else
        begin
            dst = rt;
            case (op)
                OP_J:     begin wr = 1'b0; npc = {6'd0, w[25:0]}; end
                OP_JAL:
                begin
                    dst = 5'd31;
                    val = pc_reg + 32'd64;
                    npc = {6'd0, w[25:0]};
                end
                OP_BEQ:   begin wr = 1'b0; if (a == b) npc = pc_reg + si; end
                OP_BNE:   begin wr = 1'b0; if (a != b) npc = pc_reg + si; end
                OP_ADDI:  begin val = sum_ai; ovf = ~(a[31] ^ si[31]) & (a[31] ^ val[31]); end
                OP_ADDIU: val = sum_ai;
                OP_SLTI:  val = {31'd0, $signed(a) < $signed(si)};
                OP_SLTIU: val = {31'd0, a < si};
                OP_ANDI:  val = a & zi;
                OP_ORI:   val = a | zi;
                default:  begin wr = 1'b0; bad = 1'b1; end
            endcase
        end
        if (q_word.cls == CL_MUL || q_word.cls == CL_DIV)
            wr = 1'b0;
        if (wr && dst == 5'd0)
            wr = 1'b0;
        if (!wr)
        begin
            dst = '0;
            val = '0;
        end
    end

    // output register holds; accept from queue when out slot free or being taken and unit idle
    assign q_ready   = (st_reg == S_IDLE) && (!valid || ready);
    assign fire      = q_valid && q_ready;
    assign start_mul = fire && q_word.cls == CL_MUL;
    assign start_div = fire && q_word.cls == CL_DIV && b != 32'd0;
    assign finish    = st_reg == S_FIX;

    // shift-add multiply step, restoring divide step
    assign prod = acc_reg[0] ? ({1'b0, acc_reg[63:32]} + {1'b0, mcand_reg})
                             : {1'b0, acc_reg[63:32]};
    assign dsub = {acc_reg[63:31]} - {1'b0, dvs_reg};
    assign mdone = neg_reg ? (64'd0 - acc_reg) : acc_reg;
    assign q_fix = neg_reg ? (32'd0 - acc_reg[31:0]) : acc_reg[31:0];
    assign r_fix = rneg_reg ? (32'd0 - acc_reg[63:32]) : acc_reg[63:32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            rvld_reg <= '0;
            hi_reg   <= '0;
            lo_reg   <= '0;
            pc_reg   <= '0;
            valid    <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            // raise the result word for an op that skips the unit or a finished unit, drop it once taken
            if ((fire && !start_mul && !start_div) || finish)
                valid <= 1'b1;
            else if (ready)
                valid <= 1'b0;
            case (st_reg)
                S_IDLE:
                begin
                    if (fire)
                    begin
                        pc_reg <= npc;
                        if (wr)
                            rvld_reg[dst] <= 1'b1;
                        if (q_word.cls == CL_DIV && b == 32'd0)
                        begin
                            lo_reg <= '1;
                            hi_reg <= a;
                        end
                        if (start_mul || start_div)
                        begin
                            cnt_reg <= 6'd32;
                            st_reg  <= start_mul ? S_MUL : S_DIV;
                        end
                    end
                end
                S_MUL:
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                        st_reg <= S_FIX;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                        st_reg <= S_FIX;
                end
                S_FIX:
                begin
                    if (ov_reg)
                    begin
                        lo_reg <= q_fix;
                        hi_reg <= r_fix;
                    end
                    else
                    begin
                        lo_reg <= mdone[31:0];
                        hi_reg <= mdone[63:32];
                    end
                    st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    // datapath of the iterative unit and result word
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            next_pc     <= npc;
            reg_write   <= wr;
            reg_index   <= dst;
            reg_value   <= val;
            overflow    <= ovf;
            unsupported <= bad || q_word.cls == CL_BAD;
            if (wr)
                regs_reg[dst] <= val;
            acc_reg   <= {32'd0, abs_a};
            mcand_reg <= abs_b;
            dvs_reg   <= abs_b;
            ov_reg    <= q_word.cls == CL_DIV;
            neg_reg   <= q_word.sgn && (a[31] ^ b[31]);
            rneg_reg  <= q_word.sgn && a[31];
        end
        else if (st_reg == S_MUL)
            acc_reg <= {prod, acc_reg[31:1]};
        else if (st_reg == S_DIV)
        begin
            if (!dsub[32])
                acc_reg <= {dsub[31:0], acc_reg[30:0], 1'b1};
            else
                acc_reg <= {acc_reg[62:0], 1'b0};
        end
    end

endmodule

// ===== design/mips_integer_execute.sv =====
// channel | direction | handshake       | payload
// in      | to block  | valid / ready   | instr
// out     | from block| out_valid/out_ready | next_pc reg_write reg_index reg_value
//         |           |                 | overflow unsupported
// Simple instructions are stored in the queue, then registered into the back end output word.
// mult, multu, div, divu run in the shared shift/subtract unit (a start, 32 steps and a
// sign fixup); divide by zero skips the unit and finishes like a simple instruction.
// Reset clears the register file valid bits, HI, LO and PC; no clearing pass.
// The two-entry queue keeps accepting while the back end is busy or stalled, until both entries are full.
module mips_integer_execute (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        ready,
    input  logic [31:0] instr,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] next_pc,
    output logic        reg_write,
    output logic [4:0]  reg_index,
    output logic [31:0] reg_value,
    output logic        overflow,
    output logic        unsupported
);
    import mie_pkg::*;

    logic q_valid, q_ready;
    dec_word_t q_word;

    mie_front u_front (
        .clk(clk), .rst_n(rst_n), .valid(valid), .ready(ready), .instr(instr),
        .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word)
    );

    mie_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_word(q_word), .valid(out_valid), .ready(out_ready),
        .next_pc(next_pc), .reg_write(reg_write), .reg_index(reg_index),
        .reg_value(reg_value), .overflow(overflow), .unsupported(unsupported)
    );

`ifndef SYNTHESIS
    a_no_r0: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reg_write |-> reg_index != 5'd0) else $error("r0 written");
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !reg_write |-> reg_value == 32'd0) else $error("stray value");
    a_bad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unsupported |-> !reg_write && !overflow) else $error("bad op wrote");
`endif

endmodule

// ===== tb/sv/tb_mips_integer_execute.sv =====
module tb_mips_integer_execute;
    import mie_pkg::*;

    typedef struct {
        logic [31:0] next_pc;
        logic        reg_write;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        overflow;
        logic        unsupported;
    } exec_result_t;

    logic        clk;
    logic        rst_n;
    logic        valid;
    logic        ready;
    logic [31:0] instr;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] next_pc;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        overflow;
    logic        unsupported;

    // architectural state mirrored by the predictor
    logic [31:0] gpr [NREGS];
    logic [31:0] hi_q;
    logic [31:0] lo_q;
    logic [31:0] pc_q;

    exec_result_t pending_results[$];
    int  error_count;
    int  idle_cycles;
    bit  quiet_mode;
    bit  timed_out;

    mips_integer_execute DUT (
        .clk(clk), .rst_n(rst_n), .valid(valid), .ready(ready), .instr(instr),
        .out_valid(out_valid), .out_ready(out_ready), .next_pc(next_pc),
        .reg_write(reg_write), .reg_index(reg_index), .reg_value(reg_value),
        .overflow(overflow), .unsupported(unsupported)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // compute the result of one instruction and advance the mirrored state
    function automatic exec_result_t execute_instr(logic [31:0] w);
        exec_result_t r;
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [4:0]  sh;
        logic [4:0]  dst;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] si;
        logic [31:0] zi;
        logic [31:0] val;
        logic [31:0] npc;
        logic [63:0] prod;
        logic        wr;
        logic        ovf;
        logic        bad;
        op  = w[31:26];
        fn  = w[5:0];
        sh  = w[10:6];
        a   = gpr[w[25:21]];
        b   = gpr[w[20:16]];
        si  = {{16{w[15]}}, w[15:0]};
        zi  = {16'h0, w[15:0]};
        npc = pc_q + 32'd32;
        wr  = 1'b1;
        ovf = 1'b0;
        bad = 1'b0;
        val = '0;
        if (op == OP_RTYPE)
        begin
            dst = w[15:11];
            case (fn)
                FN_SLL:   val = b << sh;
                FN_SRL:   val = b >> sh;
                FN_JR:
                begin
                    wr = 1'b0;
                    npc = a;
                end
                FN_MFHI:  val = hi_q;
                FN_MFLO:  val = lo_q;
                FN_MULT:
                begin
                    prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                    {hi_q, lo_q} = prod;
                    wr = 1'b0;
                end
                FN_MULTU:
                begin
                    prod = {32'h0, a} * {32'h0, b};
                    {hi_q, lo_q} = prod;
                    wr = 1'b0;
                end
                FN_DIV:
                begin
                    if (b == 0)
                    begin
                        lo_q = '1;
                        hi_q = a;
                    end
                    else if (a == 32'h8000_0000 && b == 32'hffff_ffff)
                    begin
                        lo_q = 32'h8000_0000;
                        hi_q = '0;
                    end
                    else
                    begin
                        lo_q = $signed(a) / $signed(b);
                        hi_q = $signed(a) % $signed(b);
                    end
                    wr = 1'b0;
                end
                FN_DIVU:
                begin
                    if (b == 0)
                    begin
                        lo_q = '1;
                        hi_q = a;
                    end
                    else
                    begin
                        lo_q = a / b;
                        hi_q = a % b;
                    end
                    wr = 1'b0;
                end
                FN_ADD:
                begin
                    val = a + b;
                    ovf = (a[31] == b[31]) && (val[31] != a[31]);
                end
                FN_ADDU:  val = a + b;
                FN_SUB:
                begin
                    val = a - b;
                    ovf = (a[31] != b[31]) && (val[31] != a[31]);
                end
                FN_SUBU:  val = a - b;
                FN_AND:   val = a & b;
                FN_OR:    val = a | b;
                FN_XOR:   val = a ^ b;
                FN_NOR:   val = ~(a | b);
                FN_SLT:   val = {31'h0, $signed(a) < $signed(b)};
                FN_SLTU:  val = {31'h0, a < b};
                default:
                begin
                    wr = 1'b0;
                    bad = 1'b1;
                end
            endcase
        end
        else
        begin
            dst = w[20:16];
            case (op)
                OP_J:
                begin
                    wr = 1'b0;
                    npc = {6'h0, w[25:0]};
                end
                OP_JAL:
                begin
                    dst = 5'd31;
                    val = pc_q + 32'd64;
                    npc = {6'h0, w[25:0]};
                end
                OP_BEQ:
                begin
                    wr = 1'b0;
                    if (a == b)
                        npc = pc_q + si;
                end
                OP_BNE:
                begin
                    wr = 1'b0;
                    if (a != b)
                        npc = pc_q + si;
                end
                OP_ADDI:
                begin
                    val = a + si;
                    ovf = (a[31] == si[31]) && (val[31] != a[31]);
                end
                OP_ADDIU: val = a + si;
                OP_SLTI:  val = {31'h0, $signed(a) < $signed(si)};
                OP_SLTIU: val = {31'h0, a < si};
                OP_ANDI:  val = a & zi;
                OP_ORI:   val = a | zi;
                default:
                begin
                    wr = 1'b0;
                    bad = 1'b1;
                end
            endcase
        end
        if (dst == 0)
            wr = 1'b0;
        if (wr)
            gpr[dst] = val;
        else
        begin
            dst = '0;
            val = '0;
        end
        pc_q = npc;
        r.next_pc = npc;
        r.reg_write = wr;
        r.reg_index = dst;
        r.reg_value = val;
        r.overflow = ovf;
        r.unsupported = bad;
        return r;
    endfunction

    // send one word and queue its expected result; valid stays up for a following word
    task automatic send_word(logic [31:0] w);
        if (!quiet_mode)
        begin
            while ($urandom_range(99) < 22)
            begin
                valid <= 1'b0;
                @(posedge clk);
            end
        end
        valid <= 1'b1;
        instr <= w;
        @(posedge clk);
        while (!ready)
            @(posedge clk);
        pending_results.push_back(execute_instr(w));
    endtask

    task automatic wait_drained();
        valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [31:0] rtype(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                          logic [4:0] sh, logic [5:0] fn);
        return {OP_RTYPE, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // load a register with an arbitrary 32-bit value through ori and sll
    task automatic load_reg(logic [4:0] rd, logic [31:0] v);
        send_word(itype(OP_ORI, 5'd0, rd, v[31:16]));
        send_word(rtype(5'd0, rd, rd, 5'd16, FN_SLL));
        send_word(itype(OP_ORI, rd, rd, v[15:0]));
    endtask

    task automatic test_directed_ops();
        load_reg(5'd1, 32'h7fff_ffff);
        load_reg(5'd2, 32'h8000_0000);
        load_reg(5'd3, 32'hffff_ffff);
        send_word(rtype(5'd1, 5'd1, 5'd4, 5'd0, FN_ADD));
        send_word(rtype(5'd2, 5'd1, 5'd5, 5'd0, FN_SUB));
        send_word(itype(OP_ADDI, 5'd1, 5'd0, 16'h0001));
        send_word(rtype(5'd2, 5'd3, 5'd0, 5'd0, FN_DIV));
        send_word(rtype(5'd0, 5'd0, 5'd6, 5'd0, FN_MFLO));
        send_word(rtype(5'd1, 5'd0, 5'd0, 5'd0, FN_DIVU));
        send_word(rtype(5'd0, 5'd0, 5'd7, 5'd0, FN_MFHI));
        send_word(rtype(5'd2, 5'd3, 5'd0, 5'd0, FN_MULT));
        send_word(rtype(5'd0, 5'd0, 5'd0, 5'd0, FN_MFHI));
        send_word(rtype(5'd3, 5'd3, 5'd0, 5'd0, FN_MULTU));
        send_word(rtype(5'd3, 5'd1, 5'd8, 5'd31, FN_SRL));
        send_word(itype(OP_SLTIU, 5'd1, 5'd9, 16'hffff));
        send_word(itype(OP_SLTI, 5'd2, 5'd10, 16'h8000));
        send_word(itype(OP_ANDI, 5'd3, 5'd11, 16'hffff));
        send_word(itype(OP_BEQ, 5'd0, 5'd0, 16'hffe0));
        send_word(itype(OP_BNE, 5'd1, 5'd2, 16'h0040));
        send_word({OP_JAL, 26'h3ff_ffff});
        send_word({OP_J, 26'h000_0100});
        send_word(rtype(5'd3, 5'd0, 5'd0, 5'd0, FN_JR));
        send_word(32'hffff_ffff);
        send_word(rtype(5'd1, 5'd2, 5'd12, 5'd0, 6'h3f));
    endtask

    function automatic logic [31:0] random_word();
        logic [5:0] ops [11];
        logic [5:0] fns [19];
        logic [31:0] w;
        int sel;
        ops = '{OP_RTYPE, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDI, OP_ADDIU,
                OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI};
        fns = '{FN_SLL, FN_SRL, FN_JR, FN_MFHI, FN_MFLO, FN_MULT, FN_MULTU,
                FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND,
                FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
        w = $urandom;
        sel = $urandom_range(99);
        if (sel < 5)
            return w;
        if (sel < 55)
        begin
            w[31:26] = OP_RTYPE;
            // keep mult/div rare since they run long
            do
                w[5:0] = fns[$urandom_range(18)];
            while ((w[5:0] inside {FN_MULT, FN_MULTU, FN_DIV, FN_DIVU})
                   && $urandom_range(3) != 0);
        end
        else
            w[31:26] = ops[$urandom_range(1, 10)];
        return w;
    endfunction

    task automatic test_random_stream(int count);
        for (int i = 0; i < count; i++)
        begin
            quiet_mode = (i >= count / 3 && i < count / 2);
            send_word(random_word());
        end
        quiet_mode = 1'b0;
    endtask

    task automatic test_drain_pause();
        wait_drained();
        for (int i = 0; i < 20; i++)
            send_word(random_word());
    endtask

    // accept results with random back-pressure and check them
    always @(posedge clk)
    begin
        exec_result_t e;
        if (rst_n)
        begin
            out_ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 22);
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with none expected, next_pc %h", $time, next_pc);
                    error_count++;
                end
                else
                begin
                    e = pending_results.pop_front();
                    if (e.next_pc !== next_pc)
                    begin
                        $display("%0t: next_pc expected %h actual %h", $time, e.next_pc,
                                 next_pc);
                        error_count++;
                    end
                    if (e.reg_write !== reg_write)
                    begin
                        $display("%0t: reg_write expected %b actual %b", $time,
                                 e.reg_write, reg_write);
                        error_count++;
                    end
                    if (e.reg_index !== reg_index)
                    begin
                        $display("%0t: reg_index expected %0d actual %0d", $time,
                                 e.reg_index, reg_index);
                        error_count++;
                    end
                    if (e.reg_value !== reg_value)
                    begin
                        $display("%0t: reg_value expected %h actual %h", $time,
                                 e.reg_value, reg_value);
                        error_count++;
                    end
                    if (e.overflow !== overflow)
                    begin
                        $display("%0t: overflow expected %b actual %b", $time,
                                 e.overflow, overflow);
                        error_count++;
                    end
                    if (e.unsupported !== unsupported)
                    begin
                        $display("%0t: unsupported expected %b actual %b", $time,
                                 e.unsupported, unsupported);
                        error_count++;
                    end
                end
            end
        end
    end

    // count cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((valid && ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000 && !timed_out)
        begin
            timed_out = 1'b1;
            $display("mips_integer_execute verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        valid = 1'b0;
        instr = '0;
        out_ready = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        quiet_mode = 1'b0;
        timed_out = 1'b0;
        for (int i = 0; i < NREGS; i++)
            gpr[i] = '0;
        hi_q = '0;
        lo_q = '0;
        pc_q = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_ops();
        test_drain_pause();
        test_random_stream(1650);
        wait_drained();
        if (error_count == 0)
            $display("mips_integer_execute verification clean");
        else
            $display("mips_integer_execute verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/mie_pkg.sv
design/mie_front.sv
design/mie_back.sv
design/mips_integer_execute.sv
tb/sv/tb_mips_integer_execute.sv
